/* rtl/lpht_pkg.sv */
// Package for the linear probing hash table.
// Holds table sizing, status and action codes, item and entry types, and the FSM states.
// No dependencies.
package lpht_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 64;
  localparam int ID_W       = 64;
  localparam int AGE_W      = 7;
  localparam int SLOT_W     = 6;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    action_t               action;
    logic [KEY_W-1:0]      key;
    logic [ID_W-1:0]       record_id;
    logic [AGE_W-1:0]      age;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       found_id;
    logic [AGE_W-1:0]      found_age;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [ID_W-1:0]       record_id;
    logic [AGE_W-1:0]      age;
  } entry_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      addr;
    entry_t                wdata;
  } ram_req_t;

endpackage

/* rtl/lpht_if.sv */
// Valid/ready channel interfaces for the hash table request and result items.
// Depends on lpht_pkg for field widths.
interface lpht_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [lpht_pkg::KEY_W-1:0]   key;
  logic [lpht_pkg::ID_W-1:0]    record_id;
  logic [lpht_pkg::AGE_W-1:0]   age;

  modport source (output valid, action, key, record_id, age, input ready);
  modport sink   (input valid, action, key, record_id, age, output ready);
endinterface

interface lpht_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [lpht_pkg::SLOT_W-1:0]  slot;
  logic [lpht_pkg::ID_W-1:0]    found_id;
  logic [lpht_pkg::AGE_W-1:0]   found_age;

  modport source (output valid, status, slot, found_id, found_age, input ready);
  modport sink   (input valid, status, slot, found_id, found_age, output ready);
endinterface

/* rtl/lpht_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lpht_probe.sv */
// Probe sequencer: holds the slot valid bits and walks the probe sequence over the table RAM.
// Depends on lpht_pkg.
module lpht_probe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lpht_pkg::req_t    req,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_ready,
  output lpht_pkg::res_t    res,
  output lpht_pkg::ram_req_t ram_req,
  input  lpht_pkg::entry_t  ram_rdata
);

  lpht_pkg::state_t                 state_r, state_nxt;
  lpht_pkg::req_t                   req_r, req_nxt;
  lpht_pkg::res_t                   res_r, res_nxt;
  logic [lpht_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [lpht_pkg::IDX_W-1:0]       home_r, home_nxt;
  logic [lpht_pkg::IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [lpht_pkg::TABLE_SIZE-1:0]  valid_r, valid_nxt;

  logic [15:0]                      home_prod;
  logic [lpht_pkg::IDX_W-1:0]       idx_inc;
  logic                             cur_valid;
  logic                             last_probe;
  logic                             key_hit;
  logic                             is_insert;

  // The table size is a power of two, so the home slot is the low bits of the product.
  assign home_prod  = req.key[7:0] * req.key[15:8];
  assign idx_inc    = (idx_r == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1)) ?
                      '0 : idx_r + lpht_pkg::IDX_W'(1);
  assign cur_valid  = valid_r[idx_r];
  assign last_probe = (cnt_r == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1));
  assign key_hit    = (ram_rdata.key == req_r.key);
  assign is_insert  = (req_r.action == lpht_pkg::ACT_INSERT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lpht_pkg::ST_PROBE;
        end
      end
      lpht_pkg::ST_PROBE: begin
        if (is_insert) begin
          if (!cur_valid || last_probe) begin
            state_nxt = lpht_pkg::ST_EMIT;
          end
        end else if (!cur_valid) begin
          state_nxt = lpht_pkg::ST_EMIT;
        end else begin
          state_nxt = lpht_pkg::ST_CMP;
        end
      end
      lpht_pkg::ST_CMP: begin
        if (key_hit || last_probe) begin
          state_nxt = lpht_pkg::ST_EMIT;
        end else begin
          state_nxt = lpht_pkg::ST_PROBE;
        end
      end
      lpht_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = lpht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy              = (state_r != lpht_pkg::ST_IDLE);
    res_valid         = (state_r == lpht_pkg::ST_EMIT);
    ram_req.we        = (state_r == lpht_pkg::ST_PROBE) && is_insert && !cur_valid;
    ram_req.addr      = idx_r;
    ram_req.wdata.key       = req_r.key;
    ram_req.wdata.record_id = req_r.record_id;
    ram_req.wdata.age       = req_r.age;
  end

  assign res = res_r;

  always_comb begin
    req_nxt   = req_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    home_nxt  = home_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    case (state_r)
      lpht_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt  = req;
          home_nxt = home_prod[lpht_pkg::IDX_W-1:0];
          idx_nxt  = home_prod[lpht_pkg::IDX_W-1:0];
          cnt_nxt  = '0;
        end
      end
      lpht_pkg::ST_PROBE: begin
        if (is_insert) begin
          if (!cur_valid) begin
            valid_nxt[idx_r] = 1'b1;
            res_nxt = '{status: lpht_pkg::STATUS_OK,
                        slot: lpht_pkg::SLOT_W'(idx_r),
                        found_id: '0, found_age: '0};
          end else if (last_probe) begin
            res_nxt = '{status: lpht_pkg::STATUS_FULL,
                        slot: lpht_pkg::SLOT_W'(home_r),
                        found_id: '0, found_age: '0};
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_r + lpht_pkg::IDX_W'(1);
          end
        end else if (!cur_valid) begin
          res_nxt = '{status: lpht_pkg::STATUS_NOT_FOUND,
                      slot: lpht_pkg::SLOT_W'(home_r),
                      found_id: '0, found_age: '0};
        end
      end
      lpht_pkg::ST_CMP: begin
        if (key_hit) begin
          res_nxt = '{status: lpht_pkg::STATUS_OK,
                      slot: lpht_pkg::SLOT_W'(idx_r),
                      found_id: ram_rdata.record_id,
                      found_age: ram_rdata.age};
        end else if (last_probe) begin
          res_nxt = '{status: lpht_pkg::STATUS_NOT_FOUND,
                      slot: lpht_pkg::SLOT_W'(home_r),
                      found_id: '0, found_age: '0};
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + lpht_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::ST_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
    home_r <= home_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

/* rtl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: channel handshakes, output register,
// table RAM and probe sequencer. Depends on lpht_pkg, lpht_if, lpht_ram and lpht_probe.
//
//   Channel   Direction  Carries
//   in_ch     sink       action, key, record_id, age
//   out_ch    source     status, slot, found_id, found_age
//
// An insert walks the slots from its home slot until it finds a free one or has probed every slot.
// A lookup spends a probe state and a compare state on each occupied slot, since
// each key compare waits on the registered read of the single table RAM.
// Reset clears the slot valid bits at once; the table RAM itself is not cleared.
// A result waits in the output register, so a new item is taken while it is stalled.
module linear_probe_hash_table (
  input logic          clk,
  input logic          rst_n,
  lpht_in_if.sink      in_ch,
  lpht_out_if.source   out_ch
);

  lpht_pkg::req_t      req;
  lpht_pkg::res_t      res;
  lpht_pkg::res_t      out_r, out_nxt;
  lpht_pkg::ram_req_t  ram_req;
  lpht_pkg::entry_t    ram_rdata;
  logic                out_valid_r, out_valid_nxt;
  logic                busy;
  logic                start;
  logic                res_valid;
  logic                res_ready;
  logic                load;

  assign req.action    = lpht_pkg::action_t'(in_ch.action);
  assign req.key       = in_ch.key;
  assign req.record_id = in_ch.record_id;
  assign req.age       = in_ch.age;

  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;
  assign res_ready   = !out_valid_r || out_ch.ready;
  assign load        = res_valid && res_ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_r.status;
  assign out_ch.slot      = out_r.slot;
  assign out_ch.found_id  = out_r.found_id;
  assign out_ch.found_age = out_r.found_age;

  lpht_ram #(
    .WIDTH ($bits(lpht_pkg::entry_t)),
    .DEPTH (lpht_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  lpht_probe u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule
